// File: sv/bvct_pkg.sv
// Shared types, codes and float helpers for the bounded value command table.
`default_nettype none
package bvct_pkg;

    // input actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_CMD  = 2'd1;
    localparam logic [1:0] ACT_UPD  = 2'd2;

    // item kinds after classification
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_UPD  = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    // command classes
    localparam logic [2:0] CLS_MIN     = 3'd0;
    localparam logic [2:0] CLS_MAX     = 3'd1;
    localparam logic [2:0] CLS_INV     = 3'd2;
    localparam logic [2:0] CLS_ARITH   = 3'd3;
    localparam logic [2:0] CLS_INVALID = 3'd4;

    // command codes that bound the classes
    localparam logic [3:0] CODE_MIN       = 4'd0;
    localparam logic [3:0] CODE_MAX       = 4'd1;
    localparam logic [3:0] CODE_INV       = 4'd2;
    localparam logic [3:0] CODE_INT_FIRST = 4'd3;
    localparam logic [3:0] CODE_FLT_FIRST = 4'd9;
    localparam logic [3:0] CODE_LAST      = 4'd12;

    // arithmetic operations
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_REFUSE   = 2'd2;

    // float unit operations
    localparam logic [1:0] FOP_ADD = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_U2F = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cls;
        logic [1:0]  op;
        logic        clamp;
        logic        unit_float;
        logic [3:0]  entry_index;
        logic [15:0] channel;
        logic        is_number;
        logic [31:0] lower;
        logic [31:0] upper;
        logic [31:0] operand;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [31:0] value;
    } result_t;

    function automatic logic f_is_nan(input logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic f_is_inf(input logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    // a <= b, false when unordered
    function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        if (f_is_nan(a) || f_is_nan(b)) begin
            return 1'b0;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return 1'b1;
        end
        return ka <= kb;
    endfunction

    // truncate toward zero, saturate high, NaN and negatives give zero
    function automatic logic [31:0] f_to_uint(input logic [31:0] x);
        logic [55:0] m;
        logic [7:0]  e;
        m = {32'd0, 1'b1, x[22:0]};
        e = x[30:23];
        if (f_is_nan(x) || x[31]) begin
            return 32'd0;
        end
        if (e >= 8'd159) begin
            return 32'hFFFF_FFFF;
        end
        if (e < 8'd127) begin
            return 32'd0;
        end
        if (e >= 8'd150) begin
            return 32'(m << (e - 8'd150));
        end
        return 32'(m >> (8'd150 - e));
    endfunction

endpackage
`default_nettype wire

// File: sv/bvct_front.sv
// Front end: accept input words, classify them and queue them for the back end.
`default_nettype none
module bvct_front #(
    parameter int ENTRIES = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [1:0]       s_tuser,
    input  wire logic [127:0]     s_tdata,
    output logic                  q_valid,
    input  wire logic             q_pop,
    output bvct_pkg::item_t       q_item
);

    localparam int QDEPTH = 2;

    bvct_pkg::item_t item_in;
    bvct_pkg::item_t q_mem [QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg,  count_next;
    logic [3:0]      code;
    logic [3:0]      base;
    logic            push;

    assign code = s_tdata[88:85];

    // classify the incoming word
    always_comb begin
        item_in.entry_index = s_tdata[3:0];
        item_in.channel     = s_tdata[19:4];
        item_in.is_number   = s_tdata[20];
        item_in.lower       = s_tdata[52:21];
        item_in.upper       = s_tdata[84:53];
        item_in.operand     = s_tdata[120:89];
        case (s_tuser)
            bvct_pkg::ACT_LOAD: begin
                item_in.kind = (32'(s_tdata[3:0]) < ENTRIES) ? bvct_pkg::KIND_LOAD
                                                              : bvct_pkg::KIND_BAD;
            end
            bvct_pkg::ACT_CMD: item_in.kind = bvct_pkg::KIND_CMD;
            bvct_pkg::ACT_UPD: item_in.kind = bvct_pkg::KIND_UPD;
            default:           item_in.kind = bvct_pkg::KIND_BAD;
        endcase
        case (code)
            bvct_pkg::CODE_MIN: item_in.cls = bvct_pkg::CLS_MIN;
            bvct_pkg::CODE_MAX: item_in.cls = bvct_pkg::CLS_MAX;
            bvct_pkg::CODE_INV: item_in.cls = bvct_pkg::CLS_INV;
            default: begin
                if (code inside {[bvct_pkg::CODE_INT_FIRST:bvct_pkg::CODE_LAST]}) begin
                    item_in.cls = bvct_pkg::CLS_ARITH;
                end else begin
                    item_in.cls = bvct_pkg::CLS_INVALID;
                end
            end
        endcase
        item_in.unit_float = code >= bvct_pkg::CODE_FLT_FIRST;
        base = item_in.unit_float ? (code - bvct_pkg::CODE_FLT_FIRST)
                                  : (code - bvct_pkg::CODE_INT_FIRST);
        item_in.op    = base[2:1];
        item_in.clamp = base[0];
    end

    assign s_tready = count_reg != 2'(QDEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

// File: sv/bvct_fpu.sv
// Multi-cycle single-precision adder and integer-to-float converter.
`default_nettype none
module bvct_fpu (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bvct_pkg::fpu_req_t req,
    output bvct_pkg::fpu_rsp_t      rsp
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_ALIGN = 3'd1;
    localparam logic [2:0] F_SUM   = 3'd2;
    localparam logic [2:0] F_NORM  = 3'd3;
    localparam logic [2:0] F_RND   = 3'd4;

    logic [2:0]  st_reg,   st_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg,  res_next;
    logic [31:0] x_reg,    x_next;
    logic [31:0] y_reg,    y_next;
    logic        sgn_reg,  sgn_next;
    logic        sb_reg,   sb_next;
    logic [8:0]  e_reg,    e_next;
    logic [26:0] ma_reg,   ma_next;
    logic [26:0] mb_reg,   mb_next;
    logic [31:0] w_reg,    w_next;

    logic [31:0] bn;
    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [4:0]  dd;
    logic [53:0] tmp;
    logic [27:0] s;
    logic        same;
    logic [23:0] m;
    logic        inc;
    logic [24:0] m25;
    logic [23:0] mant;
    logic [8:0]  en;

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    always_comb begin
        st_next   = st_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sgn_next  = sgn_reg;
        sb_next   = sb_reg;
        e_next    = e_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        w_next    = w_reg;

        // negate the subtrahend unless it is a NaN, which keeps its sign
        bn = ((req.op == bvct_pkg::FOP_SUB) && !bvct_pkg::f_is_nan(req.b))
             ? {~req.b[31], req.b[30:0]} : req.b;

        swap = y_reg[30:0] > x_reg[30:0];
        big  = swap ? y_reg : x_reg;
        sml  = swap ? x_reg : y_reg;
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb - es;
        dd   = (d > 8'd27) ? 5'd27 : d[4:0];
        tmp  = {(sml[30:23] != 8'd0), sml[22:0], 3'd0, 27'd0} >> dd;

        same = sgn_reg == sb_reg;
        s    = same ? ({1'b0, ma_reg} + {1'b0, mb_reg}) : ({1'b0, ma_reg} - {1'b0, mb_reg});

        m    = w_reg[31:8];
        inc  = w_reg[7] && ((|w_reg[6:0]) || w_reg[8]);
        m25  = {1'b0, m} + 25'(inc);
        mant = m25[24] ? m25[24:1] : m25[23:0];
        en   = m25[24] ? (e_reg + 9'd1) : e_reg;

        case (st_reg)
            F_IDLE: begin
                if (req.start) begin
                    if (req.op == bvct_pkg::FOP_U2F) begin
                        if (req.a == 32'd0) begin
                            res_next  = 32'd0;
                            done_next = 1'b1;
                        end else begin
                            w_next   = req.a;
                            e_next   = 9'd158;
                            sgn_next = 1'b0;
                            st_next  = F_NORM;
                        end
                    end else if (bvct_pkg::f_is_nan(req.a)) begin
                        res_next  = req.a | 32'h0040_0000;
                        done_next = 1'b1;
                    end else if (bvct_pkg::f_is_nan(req.b)) begin
                        res_next  = req.b | 32'h0040_0000;
                        done_next = 1'b1;
                    end else if (bvct_pkg::f_is_inf(req.a) && bvct_pkg::f_is_inf(bn)
                                 && (req.a[31] != bn[31])) begin
                        res_next  = 32'hFFC0_0000;
                        done_next = 1'b1;
                    end else if (bvct_pkg::f_is_inf(req.a)) begin
                        res_next  = req.a;
                        done_next = 1'b1;
                    end else if (bvct_pkg::f_is_inf(bn)) begin
                        res_next  = bn;
                        done_next = 1'b1;
                    end else begin
                        x_next  = req.a;
                        y_next  = bn;
                        st_next = F_ALIGN;
                    end
                end
            end
            F_ALIGN: begin
                // larger magnitude first, shift the smaller with sticky
                ma_next  = {(big[30:23] != 8'd0), big[22:0], 3'd0};
                mb_next  = {tmp[53:28], tmp[27] | (|tmp[26:0])};
                e_next   = {1'b0, eb};
                sgn_next = big[31];
                sb_next  = sml[31];
                st_next  = F_SUM;
            end
            F_SUM: begin
                if (s == 28'd0) begin
                    res_next  = {same ? sgn_reg : 1'b0, 31'd0};
                    done_next = 1'b1;
                    st_next   = F_IDLE;
                end else if (s[27]) begin
                    w_next  = {s[27:1], s[0], 4'd0};
                    e_next  = e_reg + 9'd1;
                    st_next = F_NORM;
                end else begin
                    w_next  = {s[26:0], 5'd0};
                    st_next = F_NORM;
                end
            end
            F_NORM: begin
                // one bit a cycle until the leading one or the denormal floor
                if (w_reg[31] || (e_reg == 9'd1)) begin
                    st_next = F_RND;
                end else begin
                    w_next = {w_reg[30:0], 1'b0};
                    e_next = e_reg - 9'd1;
                end
            end
            F_RND: begin
                if (en >= 9'd255) begin
                    res_next = {sgn_reg, 8'hFF, 23'd0};
                end else begin
                    res_next = {sgn_reg, mant[23] ? en[7:0] : 8'd0, mant[22:0]};
                end
                done_next = 1'b1;
                st_next   = F_IDLE;
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= F_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        sgn_reg <= sgn_next;
        sb_reg  <= sb_next;
        e_reg   <= e_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        w_reg   <= w_next;
    end

endmodule
`default_nettype wire

// File: sv/bvct_back.sv
// Back end: table memories, channel search, command execution and result register.
`default_nettype none
module bvct_back #(
    parameter int ENTRIES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [4:0]         entries_in_use,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire bvct_pkg::item_t    q_item,
    output bvct_pkg::fpu_req_t      fpu_req,
    input  wire bvct_pkg::fpu_rsp_t fpu_rsp,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bvct_pkg::result_t       m_result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_FPU   = 3'd4;
    localparam logic [2:0] S_FCHK  = 3'd5;

    localparam logic [2:0] SEQ_CONV = 3'd0;
    localparam logic [2:0] SEQ_ADD  = 3'd1;
    localparam logic [2:0] SEQ_INV1 = 3'd2;
    localparam logic [2:0] SEQ_INV2 = 3'd3;
    localparam logic [2:0] SEQ_INV3 = 3'd4;

    logic [2:0]        state_reg, state_next;
    bvct_pkg::item_t   item_reg,  item_next;
    logic [IW-1:0]     ent_reg,   ent_next;
    logic [IW:0]       probe_reg, probe_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IW-1:0]     chk_idx_reg,   chk_idx_next;
    logic [2:0]        seq_reg,   seq_next;
    logic [31:0]       v_reg,     v_next;
    logic              out_valid_reg, out_valid_next;
    bvct_pkg::result_t out_reg,   out_next;
    logic [ENTRIES-1:0] vld_reg;

    logic [15:0] chan_mem [ENTRIES];
    logic [31:0] lo_mem   [ENTRIES];
    logic [31:0] hi_mem   [ENTRIES];
    logic        type_mem [ENTRIES];
    logic [31:0] val_mem  [ENTRIES];
    logic [15:0] chan_q;
    logic [31:0] lo_q, hi_q, val_q;
    logic        type_q, vld_q;

    logic [CW-1:0] cfg_ext;
    logic [IW:0]   limit;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] ld_addr;
    logic          tbl_we;
    logic          val_we;
    logic [31:0]   val_wd;
    logic [31:0]   cur;
    logic [31:0]   nv0, nvi;
    logic          fin;
    logic          in_rng, v_gt, v_lt;

    assign cfg_ext  = CW'(entries_in_use);
    assign limit    = (cfg_ext < CW'(ENTRIES)) ? (IW+1)'(cfg_ext) : (IW+1)'(ENTRIES);
    assign rd_addr  = (state_reg == S_SRCH) ? probe_reg[IW-1:0] : ent_reg;
    assign ld_addr  = IW'(q_item.entry_index);
    assign cur      = vld_q ? val_q : 32'd0;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        ent_next       = ent_reg;
        probe_next     = probe_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        seq_next       = seq_reg;
        v_next         = v_reg;
        out_next       = out_reg;
        fin            = 1'b0;
        q_pop          = 1'b0;
        tbl_we         = 1'b0;
        val_we         = 1'b0;
        val_wd         = 32'd0;
        fpu_req        = '0;

        nv0 = item_reg.unit_float ? bvct_pkg::f_to_uint(item_reg.operand) : item_reg.operand;
        case (item_reg.op)
            bvct_pkg::OP_ADD: nvi = cur + nv0;
            bvct_pkg::OP_SUB: nvi = (nv0 > cur) ? 32'd0 : (cur - nv0);
            default:          nvi = nv0;
        endcase

        in_rng = bvct_pkg::f_le(v_reg, hi_q) && bvct_pkg::f_le(lo_q, v_reg);
        v_gt   = !bvct_pkg::f_is_nan(v_reg) && !bvct_pkg::f_is_nan(hi_q)
                 && !bvct_pkg::f_le(v_reg, hi_q);
        v_lt   = !bvct_pkg::f_is_nan(v_reg) && !bvct_pkg::f_is_nan(lo_q)
                 && !bvct_pkg::f_le(lo_q, v_reg);

        case (state_reg)
            S_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    case (q_item.kind)
                        bvct_pkg::KIND_LOAD: begin
                            tbl_we     = 1'b1;
                            ent_next   = ld_addr;
                            state_next = S_FETCH;
                        end
                        bvct_pkg::KIND_CMD, bvct_pkg::KIND_UPD: begin
                            probe_next     = '0;
                            chk_valid_next = 1'b0;
                            state_next     = S_SRCH;
                        end
                        default: begin
                            fin      = 1'b1;
                            out_next = '{status: bvct_pkg::ST_REFUSE, index: 4'd0,
                                         value: 32'd0};
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // one entry probed per cycle, compared in the next cycle
                if (chk_valid_reg && (chan_q == item_reg.channel)) begin
                    ent_next   = chk_idx_reg;
                    state_next = S_FETCH;
                end else if (probe_reg == limit) begin
                    fin        = 1'b1;
                    out_next   = '{status: bvct_pkg::ST_NOTFOUND, index: 4'd0,
                                   value: 32'd0};
                    state_next = S_IDLE;
                end else begin
                    probe_next     = probe_reg + (IW+1)'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = probe_reg[IW-1:0];
                end
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC: begin
                state_next = S_IDLE;
                out_next   = '{status: bvct_pkg::ST_OK, index: 4'(ent_reg), value: cur};
                fin        = 1'b1;
                case (item_reg.kind)
                    bvct_pkg::KIND_UPD: begin
                        val_we         = 1'b1;
                        val_wd         = item_reg.operand;
                        out_next.value = item_reg.operand;
                    end
                    bvct_pkg::KIND_CMD: begin
                        case (item_reg.cls)
                            bvct_pkg::CLS_MIN: begin
                                val_we         = 1'b1;
                                val_wd         = lo_q;
                                out_next.value = lo_q;
                            end
                            bvct_pkg::CLS_MAX: begin
                                val_we         = 1'b1;
                                val_wd         = hi_q;
                                out_next.value = hi_q;
                            end
                            bvct_pkg::CLS_INV: begin
                                if (type_q) begin
                                    fin         = 1'b0;
                                    fpu_req     = '{start: 1'b1, op: bvct_pkg::FOP_SUB,
                                                    a: hi_q, b: lo_q};
                                    seq_next    = SEQ_INV1;
                                    state_next  = S_FPU;
                                end else begin
                                    // ((max - min) - value) + min reduces to max - value
                                    val_we         = 1'b1;
                                    val_wd         = hi_q - cur;
                                    out_next.value = hi_q - cur;
                                end
                            end
                            bvct_pkg::CLS_ARITH: begin
                                if (type_q) begin
                                    if (item_reg.op == bvct_pkg::OP_SUB) begin
                                        out_next.status = bvct_pkg::ST_REFUSE;
                                    end else if (!item_reg.unit_float) begin
                                        fin        = 1'b0;
                                        fpu_req    = '{start: 1'b1, op: bvct_pkg::FOP_U2F,
                                                       a: item_reg.operand, b: 32'd0};
                                        seq_next   = SEQ_CONV;
                                        state_next = S_FPU;
                                    end else if (item_reg.op == bvct_pkg::OP_ADD) begin
                                        fin        = 1'b0;
                                        fpu_req    = '{start: 1'b1, op: bvct_pkg::FOP_ADD,
                                                       a: cur, b: item_reg.operand};
                                        seq_next   = SEQ_ADD;
                                        state_next = S_FPU;
                                    end else begin
                                        fin        = 1'b0;
                                        v_next     = item_reg.operand;
                                        state_next = S_FCHK;
                                    end
                                end else if ((nvi <= hi_q) && (nvi >= lo_q)) begin
                                    val_we         = 1'b1;
                                    val_wd         = nvi;
                                    out_next.value = nvi;
                                end else if (!item_reg.clamp) begin
                                    out_next.status = bvct_pkg::ST_REFUSE;
                                end else if (nvi > hi_q) begin
                                    val_we         = 1'b1;
                                    val_wd         = hi_q;
                                    out_next.value = hi_q;
                                end else if (nvi < lo_q) begin
                                    val_we         = 1'b1;
                                    val_wd         = lo_q;
                                    out_next.value = lo_q;
                                end else begin
                                    out_next.status = bvct_pkg::ST_REFUSE;
                                end
                            end
                            default: out_next.status = bvct_pkg::ST_REFUSE;
                        endcase
                    end
                    default: ;
                endcase
            end
            S_FPU: begin
                if (fpu_rsp.done) begin
                    case (seq_reg)
                        SEQ_CONV: begin
                            if (item_reg.op == bvct_pkg::OP_ADD) begin
                                fpu_req  = '{start: 1'b1, op: bvct_pkg::FOP_ADD,
                                             a: cur, b: fpu_rsp.result};
                                seq_next = SEQ_ADD;
                            end else begin
                                v_next     = fpu_rsp.result;
                                state_next = S_FCHK;
                            end
                        end
                        SEQ_ADD: begin
                            v_next     = fpu_rsp.result;
                            state_next = S_FCHK;
                        end
                        SEQ_INV1: begin
                            fpu_req  = '{start: 1'b1, op: bvct_pkg::FOP_SUB,
                                         a: fpu_rsp.result, b: cur};
                            seq_next = SEQ_INV2;
                        end
                        SEQ_INV2: begin
                            fpu_req  = '{start: 1'b1, op: bvct_pkg::FOP_ADD,
                                         a: fpu_rsp.result, b: lo_q};
                            seq_next = SEQ_INV3;
                        end
                        default: begin
                            val_we     = 1'b1;
                            val_wd     = fpu_rsp.result;
                            fin        = 1'b1;
                            out_next   = '{status: bvct_pkg::ST_OK, index: 4'(ent_reg),
                                           value: fpu_rsp.result};
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FCHK: begin
                fin        = 1'b1;
                state_next = S_IDLE;
                out_next   = '{status: bvct_pkg::ST_OK, index: 4'(ent_reg), value: cur};
                if (in_rng) begin
                    val_we         = 1'b1;
                    val_wd         = v_reg;
                    out_next.value = v_reg;
                end else if (item_reg.clamp && v_gt) begin
                    val_we         = 1'b1;
                    val_wd         = hi_q;
                    out_next.value = hi_q;
                end else if (item_reg.clamp && v_lt) begin
                    val_we         = 1'b1;
                    val_wd         = lo_q;
                    out_next.value = lo_q;
                end else begin
                    out_next.status = bvct_pkg::ST_REFUSE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (fin) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chk_valid_reg <= chk_valid_next;
            if (val_we) begin
                vld_reg[ent_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        ent_reg     <= ent_next;
        probe_reg   <= probe_next;
        chk_idx_reg <= chk_idx_next;
        seq_reg     <= seq_next;
        v_reg       <= v_next;
        out_reg     <= out_next;
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            chan_mem[ld_addr] <= q_item.channel;
            lo_mem[ld_addr]   <= q_item.lower;
            hi_mem[ld_addr]   <= q_item.upper;
            type_mem[ld_addr] <= q_item.is_number;
        end
        if (val_we) begin
            val_mem[ent_reg] <= val_wd;
        end
        chan_q <= chan_mem[rd_addr];
        lo_q   <= lo_mem[rd_addr];
        hi_q   <= hi_mem[rd_addr];
        type_q <= type_mem[rd_addr];
        val_q  <= val_mem[rd_addr];
        vld_q  <= vld_reg[rd_addr];
    end

endmodule
`default_nettype wire

// File: sv/bounded_value_command_table.sv
// Top level of the bounded value command table.
`default_nettype none
// Table of bounded values addressed by channel number. Load words write an
// entry's channel, type and bounds; command and update words search the first
// entries_in_use entries for the channel, one entry per cycle, and act on the
// lowest matching one. Each input word gives exactly one result word. A load
// passes through the fetch and execute states; a search probes entries and then
// fetches and executes. Float commands run through one shared multi-cycle adder
// whose normalization moves one bit per cycle, and an inversion chains three
// adds. A two-word queue and an output register let the input side keep taking
// words while a result waits. Stored values read as zero after reset through
// per-entry valid bits, so no clearing pass is needed. The configuration channel
// is always ready.
module bounded_value_command_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: entries_in_use
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [4:0]   cfg_data,
    // input words
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // action
    // entry_index[3:0], channel_number[19:4], is_number[20], lower_bound[52:21],
    // upper_bound[84:53], command_code[88:85], operand_bits[120:89], zero above
    input  wire logic [127:0] s_tdata,
    // result words
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [1:0]        m_tuser,   // status
    // matched_index[3:0], current_value[35:4], zero above
    output logic [39:0]       m_tdata
);

    logic [4:0]         entries_in_use_reg;
    logic               q_valid;
    logic               q_pop;
    bvct_pkg::item_t    q_item;
    bvct_pkg::fpu_req_t fpu_req;
    bvct_pkg::fpu_rsp_t fpu_rsp;
    bvct_pkg::result_t  result;

    assign cfg_ready = 1'b1;

    // hold the search count; to be written only while the block is idle, which the block itself does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= 5'd0;
        end else if (cfg_valid) begin
            entries_in_use_reg <= cfg_data;
        end
    end

    bvct_front #(.ENTRIES(ENTRIES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    bvct_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    bvct_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entries_in_use (entries_in_use_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .fpu_req        (fpu_req),
        .fpu_rsp        (fpu_rsp),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_result       (result)
    );

    // pack the result word
    assign m_tuser = result.status;
    assign m_tdata = {4'd0, result.value, result.index};

endmodule
`default_nettype wire

// File: tb/bounded_value_command_table_tb.sv
// Self-checking testbench for the bounded value command table.
`timescale 1ns / 1ps
module bounded_value_command_table_tb;

    localparam int          NENT      = 16;
    localparam int          LIMIT     = 1000000;
    localparam logic [1:0]  ACT_SPARE = 2'd3;   // unused action code

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  entry_index;
        logic [15:0] channel;
        logic        is_number;
        logic [31:0] lower;
        logic [31:0] upper;
        logic [3:0]  code;
        logic [31:0] operand;
    } word_t;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [31:0] value;
        bit          any_nan;   // value is some NaN, payload not fixed
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [1:0]   m_tuser;
    logic [39:0]  m_tdata;

    bounded_value_command_table #(.ENTRIES(NENT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow of the table state
    logic [15:0] chan_tab [NENT];
    logic [31:0] lo_tab   [NENT];
    logic [31:0] hi_tab   [NENT];
    logic        num_tab  [NENT];
    logic [31:0] val_tab  [NENT];
    bit          nan_tab  [NENT];
    logic [4:0]  search_count = '0;

    word_t       pending_words[$];
    outcome_t    due_results[$];
    word_t       word_cur;
    int          words_queued = 0;
    int          words_taken = 0;
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          stall_req = 1'b0;
    bit          stall_done = 1'b0;
    int          stall_left = 0;
    logic [15:0] chan_pool[6];

    // ---------------- single precision arithmetic via double ----------------
    function automatic bit is_nan32(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // exact widening of single bits to a real
    function automatic real widen(input logic [31:0] x);
        real r;
        if (x[30:23] == 8'hFF) begin
            return $bitstoreal({x[31], 11'h7FF, x[22:0], 29'd0});
        end
        if (x[30:23] == 8'd0) begin
            r = real'(x[22:0]) * (2.0 ** -149);
            return x[31] ? -r : r;
        end
        return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
    endfunction

    // round a real to single, nearest even; double rounding is harmless for
    // a sum of two singles
    function automatic logic [31:0] narrow(input real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          ex;
        int          es;
        int          sh;
        d  = $realtobits(r);
        ex = int'(d[62:52]);
        if (ex == 2047) begin
            return (d[51:0] != 52'd0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
        end
        if (ex == 0) begin
            return {d[63], 31'd0};
        end
        es = ex - 1023 + 127;
        if (es >= 255) begin
            return {d[63], 8'hFF, 23'd0};
        end
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (es >= 1) ? 29 : 30 - es;
        if (sh > 60) begin
            return {d[63], 31'd0};
        end
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
        end
        if (es >= 1) begin
            q = q + (64'(es - 1) << 23);
        end
        return {d[63], q[30:0]};
    endfunction

    function automatic logic [31:0] single_to_u32(input logic [31:0] x);
        real r;
        if (is_nan32(x)) begin
            return 32'd0;
        end
        r = widen(x);
        if (r < 1.0) begin
            return 32'd0;
        end
        if (r >= 4294967296.0) begin
            return 32'hFFFF_FFFF;
        end
        return 32'(longint'($floor(r)));
    endfunction

    // ---------------- command execution on one entry ----------------
    function automatic bit apply_command(input int e, input logic [3:0] code,
                                         input logic [31:0] operand);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] cur;
        logic [31:0] nv;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [3:0]  rel;
        logic [1:0]  op;
        bit          clamp;
        bit          fcmd;
        bit          vn;
        bit          ln;
        bit          hn;
        real         rv;
        real         rl;
        real         rh;
        lo  = lo_tab[e];
        hi  = hi_tab[e];
        cur = val_tab[e];
        if (code == bvct_pkg::CODE_MIN) begin
            val_tab[e] = lo; nan_tab[e] = 0; return 1;
        end
        if (code == bvct_pkg::CODE_MAX) begin
            val_tab[e] = hi; nan_tab[e] = 0; return 1;
        end
        if (code == bvct_pkg::CODE_INV) begin
            if (num_tab[e]) begin
                r1 = narrow(widen(hi) - widen(lo));
                r2 = narrow(widen(r1) - widen(cur));
                val_tab[e] = narrow(widen(r2) + widen(lo));
                nan_tab[e] = is_nan32(val_tab[e]);
            end else begin
                val_tab[e] = ((hi - lo) - cur) + lo;
                nan_tab[e] = 0;
            end
            return 1;
        end
        if (code > bvct_pkg::CODE_LAST) begin
            return 0;
        end
        fcmd  = (code >= bvct_pkg::CODE_FLT_FIRST);
        rel   = fcmd ? code - bvct_pkg::CODE_FLT_FIRST : code - bvct_pkg::CODE_INT_FIRST;
        op    = rel[2:1];
        clamp = rel[0];
        nv    = operand;
        if (fcmd && !num_tab[e]) begin
            nv = single_to_u32(operand);
        end else if (!fcmd && num_tab[e]) begin
            nv = narrow(real'(longint'({32'd0, operand})));
        end
        if (num_tab[e]) begin
            if (op == bvct_pkg::OP_SUB) begin
                return 0;
            end
            if (op == bvct_pkg::OP_ADD) begin
                nv = narrow(widen(cur) + widen(nv));
            end
            vn = is_nan32(nv);
            ln = is_nan32(lo);
            hn = is_nan32(hi);
            rv = widen(nv);
            rl = widen(lo);
            rh = widen(hi);
            if (!vn && !ln && !hn && rv <= rh && rv >= rl) begin
                val_tab[e] = nv; nan_tab[e] = 0; return 1;
            end
            if (!clamp) begin
                return 0;
            end
            if (!vn && !hn && rv > rh) begin
                val_tab[e] = hi; nan_tab[e] = 0; return 1;
            end
            if (!vn && !ln && rv < rl) begin
                val_tab[e] = lo; nan_tab[e] = 0; return 1;
            end
            return 0;
        end
        if (op == bvct_pkg::OP_ADD) begin
            nv = cur + nv;
        end else if (op == bvct_pkg::OP_SUB) begin
            nv = (nv > cur) ? 32'd0 : cur - nv;
        end
        if (nv <= hi && nv >= lo) begin
            val_tab[e] = nv; nan_tab[e] = 0; return 1;
        end
        if (!clamp) begin
            return 0;
        end
        val_tab[e] = (nv > hi) ? hi : lo;
        nan_tab[e] = 0;
        return 1;
    endfunction

    // Work out the result word of one accepted input word and queue it
    task automatic table_step(input word_t w);
        outcome_t x;
        int       lim;
        int       hit;
        x   = '{bvct_pkg::ST_REFUSE, 4'd0, 32'd0, 1'b0};
        lim = (search_count < NENT) ? int'(search_count) : NENT;
        hit = -1;
        if (w.action == bvct_pkg::ACT_LOAD) begin
            chan_tab[w.entry_index] = w.channel;
            num_tab[w.entry_index]  = w.is_number;
            lo_tab[w.entry_index]   = w.lower;
            hi_tab[w.entry_index]   = w.upper;
            x = '{bvct_pkg::ST_OK, w.entry_index, val_tab[w.entry_index],
                  nan_tab[w.entry_index]};
        end else if (w.action == bvct_pkg::ACT_CMD || w.action == bvct_pkg::ACT_UPD) begin
            for (int i = 0; i < lim; i++) begin
                if (hit < 0 && chan_tab[i] == w.channel) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                x.status = bvct_pkg::ST_NOTFOUND;
            end else begin
                if (w.action == bvct_pkg::ACT_UPD) begin
                    val_tab[hit] = w.operand;
                    nan_tab[hit] = 0;
                    x.status = bvct_pkg::ST_OK;
                end else begin
                    x.status = apply_command(hit, w.code, w.operand) ? bvct_pkg::ST_OK
                                                                     : bvct_pkg::ST_REFUSE;
                end
                x.index   = 4'(hit);
                x.value   = val_tab[hit];
                x.any_nan = nan_tab[hit];
            end
        end
        due_results.push_back(x);
    endtask

    // ---------------- input side: drive words from the pending queue ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                table_step(word_cur);
                words_taken++;
            end
            // advance only when the slot is free; hold the word otherwise
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
                    word_cur = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= word_cur.action;
                    s_tdata  <= {7'd0, word_cur.operand, word_cur.code, word_cur.upper,
                                 word_cur.lower, word_cur.is_number, word_cur.channel,
                                 word_cur.entry_index};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result side: check words, throttle ready ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        outcome_t x;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result word", {30'd0, m_tuser}, 32'd0);
                end else begin
                    x = due_results.pop_front();
                    if (m_tuser != x.status)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, x.status});
                    if (m_tdata[3:0] != x.index)
                        report_mismatch("matched_index", {28'd0, m_tdata[3:0]},
                                        {28'd0, x.index});
                    if (x.any_nan ? !is_nan32(m_tdata[35:4]) : m_tdata[35:4] != x.value)
                        report_mismatch("current_value", m_tdata[35:4], x.value);
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (stall_req && !stall_done) begin
                stall_left <= 400;
                stall_done <= 1'b1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 37);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_float();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return {1'($urandom_range(3) == 0), 8'($urandom_range(134, 122)),
                    23'($urandom)};
        if (pick < 80)
            return {1'($urandom_range(1)), 31'd0};
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_operand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return 32'($urandom_range(300));
        if (pick < 75) return rand_float();
        return $urandom;
    endfunction

    function automatic word_t load_word(input int idx);
        word_t w;
        real   a;
        real   b;
        w = '{bvct_pkg::ACT_LOAD, 4'(idx), chan_pool[$urandom_range(5)],
              1'($urandom_range(1)), 32'd0, 32'd0, 4'($urandom), $urandom};
        if ($urandom_range(9) == 0) begin
            w.channel = 16'($urandom);
            w.lower   = $urandom;
            w.upper   = $urandom;
        end else if (w.is_number) begin
            w.lower = rand_float();
            w.upper = rand_float();
            a = widen(w.lower);
            b = widen(w.upper);
            if (!is_nan32(w.lower) && !is_nan32(w.upper) && a > b) begin
                w.lower = w.upper;
                w.upper = narrow(a);
            end
        end else begin
            w.lower = 32'($urandom_range(1000));
            w.upper = w.lower + 32'($urandom_range(2000));
        end
        return w;
    endfunction

    function automatic word_t random_word();
        word_t w;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 12) return load_word($urandom_range(NENT - 1));
        w = '{bvct_pkg::ACT_CMD, 4'($urandom), chan_pool[$urandom_range(5)],
              1'($urandom_range(1)), $urandom, $urandom, 4'($urandom_range(12)),
              rand_operand()};
        if ($urandom_range(99) < 15) w.channel = 16'($urandom);
        if ($urandom_range(99) < 10) w.code = 4'($urandom);
        if (pick >= 94) w.action = ACT_SPARE;
        else if (pick >= 72) w.action = bvct_pkg::ACT_UPD;
        return w;
    endfunction

    task automatic queue_word(input word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (!(words_taken == words_queued && due_results.size() == 0))
            @(negedge aclk);
    endtask

    task automatic write_search_count(input logic [4:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        search_count  = v;
    endtask

    task automatic random_phase(input logic [4:0] count, input int n);
        wait_idle();
        write_search_count(count);
        for (int i = 0; i < n; i++) queue_word(random_word());
    endtask

    initial begin
        word_t w;
        for (int i = 0; i < NENT; i++) begin
            val_tab[i] = 32'd0;
            nan_tab[i] = 0;
        end
        chan_pool[0] = 16'h0000;
        chan_pool[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++) chan_pool[i] = 16'($urandom);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty search range: nothing is found; then load every entry
        write_search_count(5'd0);
        w = '{bvct_pkg::ACT_CMD, 4'd0, chan_pool[1], 1'b0, 32'd0, 32'd0,
              bvct_pkg::CODE_MAX, 32'd0};
        queue_word(w);
        w.action = bvct_pkg::ACT_UPD;
        queue_word(w);
        w.action = ACT_SPARE;
        queue_word(w);
        for (int i = 0; i < NENT; i++) queue_word(load_word(i));

        // every command code on two alternating channels, plus operand extremes
        wait_idle();
        write_search_count(5'd16);
        for (int c = 0; c < 16; c++) begin
            w = '{bvct_pkg::ACT_CMD, 4'd0, chan_pool[c % 2], 1'b0, 32'd0, 32'd0, 4'(c),
                  rand_operand()};
            queue_word(w);
        end
        w.code = bvct_pkg::CODE_INT_FIRST + 4'd1;
        w.operand = 32'hFFFF_FFFF;
        queue_word(w);
        w.code = bvct_pkg::CODE_FLT_FIRST;
        w.operand = 32'h7F80_0000;
        queue_word(w);
        w.operand = 32'h7FC0_0000;
        queue_word(w);
        w.action = bvct_pkg::ACT_UPD;
        w.operand = 32'd0;
        queue_word(w);
        w.operand = 32'hFFFF_FFFF;
        queue_word(w);
        w.action = ACT_SPARE;
        queue_word(w);
        for (int i = 0; i < 70; i++) queue_word(random_word());

        random_phase(5'd1, 80);
        random_phase(5'd31, 90);
        stall_req = 1'b1;
        random_phase(5'd7, 90);
        calm = 1'b1;
        random_phase(5'd16, 90);
        wait_idle();
        calm = 1'b0;
        random_phase(5'd12, 60);

        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
